// ===== rtl/core/lcd_row_pixel_packer_core_assert.svh =====
// ----------------------------------------------------------------------------
// lcd_row_pixel_packer_core_assert.svh
// Assertion macros shared by the pixel packer RTL.
// ----------------------------------------------------------------------------
`ifndef LCD_ROW_PIXEL_PACKER_CORE_ASSERT_SVH
`define LCD_ROW_PIXEL_PACKER_CORE_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define LRPP_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lrpp assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define LRPP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lrpp assertion failed");

`endif

// ===== rtl/core/lrpp_pkg.sv =====
// ----------------------------------------------------------------------------
// lrpp_pkg
// Geometry, LCD command codes and shared types of the pixel packer.
// ----------------------------------------------------------------------------
package lrpp_pkg;

    localparam int ROWS       = 128;
    localparam int COLUMNS    = 160;
    localparam int ROW_PIXELS = (COLUMNS / 8) * 8;
    localparam int COL_W      = $clog2(ROW_PIXELS);
    localparam int ROW_W      = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int GROUP_W    = 14;

    localparam logic [7:0] CMD_NOP   = 8'h00;
    localparam logic [7:0] CMD_MOVE  = 8'h11;
    localparam logic [7:0] CMD_PRINT = 8'h12;

    localparam logic TARGET_CMD  = 1'b0;
    localparam logic TARGET_DATA = 1'b1;

    typedef enum logic [7:0] {
        STEP_NOP_A  = 8'b0000_0001,
        STEP_MOVE   = 8'b0000_0010,
        STEP_ROW_HI = 8'b0000_0100,
        STEP_ROW_LO = 8'b0000_1000,
        STEP_NOP_B  = 8'b0001_0000,
        STEP_PRINT  = 8'b0010_0000,
        STEP_GRP_HI = 8'b0100_0000,
        STEP_GRP_LO = 8'b1000_0000
    } step_t;

    typedef struct packed {
        logic       header;
        logic       group;
        logic [7:0] row_hi;
        logic [7:0] row_lo;
        logic [7:0] grp_hi;
        logic [7:0] grp_lo;
    } job_t;

endpackage

// ===== rtl/core/lrpp_ifs.sv =====
// ----------------------------------------------------------------------------
// lrpp_ifs
// Valid/ready channels: pixel input and LCD register write output.
// ----------------------------------------------------------------------------
interface lrpp_pixel_if;
    logic       valid;
    logic       ready;
    logic [7:0] pixel;

    modport source (output valid, output pixel, input ready);
    modport sink   (input valid, input pixel, output ready);
endinterface

interface lrpp_write_if;
    logic       valid;
    logic       ready;
    logic       target;
    logic [7:0] value;
    logic       last;

    modport source (output valid, output target, output value, output last, input ready);
    modport sink   (input valid, input target, input value, input last, output ready);
endinterface

// ===== rtl/core/lrpp_emit.sv =====
// ----------------------------------------------------------------------------
// lrpp_emit
// Holds one job and plays out its register writes, one per transaction.
// ----------------------------------------------------------------------------
module lrpp_emit
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  lrpp_pkg::job_t       job,
    output logic                 free,
    lrpp_write_if.source         writes
);

    logic                 valid_reg;
    logic                 valid_next;
    lrpp_pkg::step_t      step_reg;
    lrpp_pkg::step_t      step_next;
    lrpp_pkg::step_t      step_after;
    lrpp_pkg::job_t       job_reg;
    logic                 fire;
    logic                 is_last;

    assign fire    = valid_reg && writes.ready;
    assign is_last = (step_reg == lrpp_pkg::STEP_GRP_LO) ||
                     ((step_reg == lrpp_pkg::STEP_PRINT) && !job_reg.group);
    assign free    = !valid_reg || (fire && is_last);

    always_comb
    begin
        case (step_reg)
            lrpp_pkg::STEP_NOP_A:  step_after = lrpp_pkg::STEP_MOVE;
            lrpp_pkg::STEP_MOVE:   step_after = lrpp_pkg::STEP_ROW_HI;
            lrpp_pkg::STEP_ROW_HI: step_after = lrpp_pkg::STEP_ROW_LO;
            lrpp_pkg::STEP_ROW_LO: step_after = lrpp_pkg::STEP_NOP_B;
            lrpp_pkg::STEP_NOP_B:  step_after = lrpp_pkg::STEP_PRINT;
            lrpp_pkg::STEP_PRINT:  step_after = lrpp_pkg::STEP_GRP_HI;
            lrpp_pkg::STEP_GRP_HI: step_after = lrpp_pkg::STEP_GRP_LO;
            default:               step_after = lrpp_pkg::STEP_NOP_A;
        endcase
    end

    always_comb
    begin
        valid_next = valid_reg;
        step_next  = step_reg;
        if (load)
        begin
            valid_next = 1'b1;
            step_next  = job.header ? lrpp_pkg::STEP_NOP_A : lrpp_pkg::STEP_GRP_HI;
        end
        else if (fire)
        begin
            if (is_last)
            begin
                valid_next = 1'b0;
            end
            else
            begin
                step_next = step_after;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            step_reg  <= lrpp_pkg::STEP_NOP_A;
        end
        else
        begin
            valid_reg <= valid_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            job_reg <= job;
        end
    end

    always_comb
    begin
        case (step_reg)
            lrpp_pkg::STEP_NOP_A:
            begin
                writes.target = lrpp_pkg::TARGET_CMD;
                writes.value  = lrpp_pkg::CMD_NOP;
            end
            lrpp_pkg::STEP_MOVE:
            begin
                writes.target = lrpp_pkg::TARGET_CMD;
                writes.value  = lrpp_pkg::CMD_MOVE;
            end
            lrpp_pkg::STEP_ROW_HI:
            begin
                writes.target = lrpp_pkg::TARGET_DATA;
                writes.value  = job_reg.row_hi;
            end
            lrpp_pkg::STEP_ROW_LO:
            begin
                writes.target = lrpp_pkg::TARGET_DATA;
                writes.value  = job_reg.row_lo;
            end
            lrpp_pkg::STEP_NOP_B:
            begin
                writes.target = lrpp_pkg::TARGET_CMD;
                writes.value  = lrpp_pkg::CMD_NOP;
            end
            lrpp_pkg::STEP_PRINT:
            begin
                writes.target = lrpp_pkg::TARGET_CMD;
                writes.value  = lrpp_pkg::CMD_PRINT;
            end
            lrpp_pkg::STEP_GRP_HI:
            begin
                writes.target = lrpp_pkg::TARGET_DATA;
                writes.value  = job_reg.grp_hi;
            end
            default:
            begin
                writes.target = lrpp_pkg::TARGET_DATA;
                writes.value  = job_reg.grp_lo;
            end
        endcase
    end

    assign writes.valid = valid_reg;
    assign writes.last  = is_last;

endmodule

// ===== rtl/core/lcd_row_pixel_packer_core.sv =====
// ----------------------------------------------------------------------------
// lcd_row_pixel_packer_core
// Packs 2-bit gray pixels into LCD controller command and data writes.
// ----------------------------------------------------------------------------
// Usage:
//   pixels : one frame buffer byte per transaction, bits 1..0 are the gray
//            level, pixels in raster order.
//   writes : one LCD register write per transaction (target 0 = command,
//            1 = data), last marks the final write caused by a pixel.
//   The first pixel of a row yields a six-write header (move, row address,
//   print); every eighth pixel of a row yields two data bytes.
//   Timing: the first write of a pixel is offered the cycle after it is
//   taken. Pixels that cause no write are taken one per cycle, also while
//   the emitter is busy. A pixel with writes holds the write register
//   until its last write leaves, as there is a single write port; the
//   next pixel with writes is taken at the earliest as that write leaves.
//   Reset clears the row, column and group state; the next pixel starts
//   row 0. A stalled receiver holds the current write steady and stops
//   pixel intake once a pixel with writes is waiting behind it.
// ----------------------------------------------------------------------------
`include "lcd_row_pixel_packer_core_assert.svh"

module lcd_row_pixel_packer_core
(
    input  logic          clk,
    input  logic          rst_n,
    lrpp_pixel_if.sink    pixels,
    lrpp_write_if.source  writes
);

    logic [lrpp_pkg::COL_W-1:0]   column_reg;
    logic [lrpp_pkg::COL_W-1:0]   column_next;
    logic [lrpp_pkg::ROW_W-1:0]   row_reg;
    logic [lrpp_pkg::ROW_W-1:0]   row_next;
    logic [lrpp_pkg::GROUP_W-1:0] group_reg;
    logic [lrpp_pkg::GROUP_W-1:0] group_next;

    logic                         accept;
    logic                         free;
    logic [2:0]                   pos;
    logic [1:0]                   gray;
    logic [7:0]                   row_y;
    logic                         row_start;
    logic                         group_done;
    lrpp_pkg::job_t               job;

    assign pos        = column_reg[2:0];
    assign gray       = pixels.pixel[1:0];
    assign row_y      = 8'(row_reg);
    assign row_start  = (column_reg == '0);
    assign group_done = (pos == 3'd7);

    // pixels without writes only touch the counters and the group, so they
    // pass while the emitter is busy
    assign pixels.ready = free || !(row_start || group_done);
    assign accept       = pixels.valid && pixels.ready;

    always_comb
    begin
        job.header = row_start;
        job.group  = group_done;
        job.row_hi = {3'b000, row_y[7:3]};
        job.row_lo = {row_y[2:0], 5'b00000};
        job.grp_hi = {gray, group_reg[13:8]};
        job.grp_lo = group_reg[7:0];
    end

    always_comb
    begin
        group_next  = group_reg;
        column_next = column_reg;
        row_next    = row_reg;
        if (accept)
        begin
            if (group_done)
            begin
                group_next = '0;
            end
            else
            begin
                group_next[{pos, 1'b0} +: 2] = gray;
            end
            if (column_reg == lrpp_pkg::COL_W'(lrpp_pkg::ROW_PIXELS - 1))
            begin
                column_next = '0;
                if (row_reg == lrpp_pkg::ROW_W'(lrpp_pkg::ROWS - 1))
                begin
                    row_next = '0;
                end
                else
                begin
                    row_next = row_reg + 1'b1;
                end
            end
            else
            begin
                column_next = column_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_reg <= '0;
            row_reg    <= '0;
            group_reg  <= '0;
        end
        else
        begin
            column_reg <= column_next;
            row_reg    <= row_next;
            group_reg  <= group_next;
        end
    end

    lrpp_emit u_emit
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (accept && (row_start || group_done)),
        .job    (job),
        .free   (free),
        .writes (writes)
    );

    `LRPP_ASSERT_SAME(a_idle_takes_pixel, !writes.valid, pixels.ready)
    `LRPP_ASSERT_NEXT(a_row_header_first, accept && row_start,
        writes.valid && writes.target == lrpp_pkg::TARGET_CMD && writes.value == lrpp_pkg::CMD_NOP)
    `LRPP_ASSERT_NEXT(a_group_cleared, accept && group_done, group_reg == '0)

endmodule
